/* src/lpw_pkg.sv */
// Shared types and constants for the line pixel walker.
package lpw_pkg;

  localparam int unsigned RedBits   = 5;
  localparam int unsigned GreenBits = 6;
  localparam int unsigned BlueBits  = 5;
  localparam int unsigned ColorBits = RedBits + GreenBits + BlueBits;

  // Entries in the queue between the front and back ends.
  localparam int unsigned QueueDepth = 2;

  typedef enum logic {
    MODE_START   = 1'b0,
    MODE_ADVANCE = 1'b1
  } mode_e;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

/* src/line_pixel_walker_unit.sv */
// Top level of the line pixel walker: front end, command queue and back end.
//
//   Channel   Direction  Handshake               Carries
//   input     in         in_valid_i/in_ready_o   mode, endpoints, RGB color
//   output    out        out_valid_o/out_ready_i pixel position, BGR565 color, flags
//
// Each accepted item produces exactly one result; the block sustains one item per
// clock while the output accepts results, limited by the walker step (error update
// and position advance). An item is registered in the queue, then in the output register.
// Reset clears the active-line flag, the queue and the output valid flag.
// When the output is stalled the back end holds its result and the two-entry queue
// absorbs incoming items; the input side stalls only when that queue is full.
module line_pixel_walker_unit #(
  parameter int unsigned COORD_BITS = 10
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [COORD_BITS-1:0]         start_x_i,
  input  logic [COORD_BITS-1:0]         start_y_i,
  input  logic [COORD_BITS-1:0]         end_x_i,
  input  logic [COORD_BITS-1:0]         end_y_i,
  input  logic [lpw_pkg::RedBits-1:0]   red_i,
  input  logic [lpw_pkg::GreenBits-1:0] green_i,
  input  logic [lpw_pkg::BlueBits-1:0]  blue_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [COORD_BITS-1:0]         pixel_x_o,
  output logic [COORD_BITS-1:0]         pixel_y_o,
  output logic [lpw_pkg::ColorBits-1:0] pixel_color_o,
  output logic                          pixel_valid_o,
  output logic                          last_pixel_o
);

  // A command carries the classified line setup; an advance item uses only its start flag.
  localparam int unsigned CmdW = 3 + 5 * COORD_BITS + lpw_pkg::ColorBits;

  logic                   push, pop;
  logic [CmdW-1:0]        cmd_in, cmd_out;
  lpw_pkg::queue_status_t q_status;

  // The front end classifies the item and, for a start, orders the endpoints.
  lpw_front #(
    .CoordBits (COORD_BITS),
    .CmdW      (CmdW)
  ) u_front (
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .mode_i     (mode_i),
    .start_x_i  (start_x_i),
    .start_y_i  (start_y_i),
    .end_x_i    (end_x_i),
    .end_y_i    (end_y_i),
    .red_i      (red_i),
    .green_i    (green_i),
    .blue_i     (blue_i),
    .q_status_i (q_status),
    .push_o     (push),
    .cmd_o      (cmd_in)
  );

  // The queue lets the input side keep going while the output side stalls.
  lpw_queue #(
    .Width (CmdW),
    .Depth (lpw_pkg::QueueDepth)
  ) u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .data_i   (cmd_in),
    .pop_i    (pop),
    .data_o   (cmd_out),
    .status_o (q_status)
  );

  // The back end runs the Bresenham step and owns the output register.
  lpw_back #(
    .CoordBits (COORD_BITS),
    .CmdW      (CmdW)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd_out),
    .q_status_i    (q_status),
    .pop_o         (pop),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .pixel_x_o     (pixel_x_o),
    .pixel_y_o     (pixel_y_o),
    .pixel_color_o (pixel_color_o),
    .pixel_valid_o (pixel_valid_o),
    .last_pixel_o  (last_pixel_o)
  );

`ifndef NO_ASSERTIONS
  // A result with no active line carries all-zero fields.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !pixel_valid_o) |->
      (pixel_x_o == '0 && pixel_y_o == '0 && pixel_color_o == '0 && !last_pixel_o))
    else $error("invalid pixel result carries nonzero fields");

  // Only a real pixel can end a line.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_pixel_o) |-> pixel_valid_o)
    else $error("last pixel flag without a valid pixel");

  // The queue can never be both empty and full.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(q_status.empty && q_status.full))
    else $error("queue reports empty and full at once");

  // An accepted input with an empty queue and a free output is written to the queue and
  // then taken by the back end, so its result is offered from then on.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && q_status.empty && (!out_valid_o || out_ready_i))
      |=> ##1 out_valid_o)
    else $error("back end failed to pick up a waiting command");
`endif

endmodule

/* src/lpw_queue.sv */
// Small register queue between the line setup front end and the pixel back end.
module lpw_queue #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 2
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  push_i,
  input  logic [Width-1:0]      data_i,
  input  logic                  pop_i,
  output logic [Width-1:0]      data_o,
  output lpw_pkg::queue_status_t status_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  logic [Width-1:0] mem_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  count_q, count_d;
  logic             do_push, do_pop;

  assign status_o.full  = (count_q == FullCnt);
  assign status_o.empty = (count_q == '0);
  assign do_push = push_i && !status_o.full;
  assign do_pop  = pop_i && !status_o.empty;
  assign data_o  = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_d = count_q + 1'b1;
    end else if (do_pop && !do_push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

/* src/lpw_front.sv */
// Front end: accepts items, decides axis swap and endpoint order for start items.
module lpw_front #(
  parameter int unsigned CoordBits = 10,
  parameter int unsigned CmdW      = 3 + 5 * CoordBits + lpw_pkg::ColorBits
) (
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic                          mode_i,
  input  logic [CoordBits-1:0]          start_x_i,
  input  logic [CoordBits-1:0]          start_y_i,
  input  logic [CoordBits-1:0]          end_x_i,
  input  logic [CoordBits-1:0]          end_y_i,
  input  logic [lpw_pkg::RedBits-1:0]   red_i,
  input  logic [lpw_pkg::GreenBits-1:0] green_i,
  input  logic [lpw_pkg::BlueBits-1:0]  blue_i,
  input  lpw_pkg::queue_status_t        q_status_i,
  output logic                          push_o,
  output logic [CmdW-1:0]               cmd_o
);

  typedef struct packed {
    logic                          is_start;
    logic                          steep;
    logic                          dir_down;
    logic [CoordBits-1:0]          major_pos;
    logic [CoordBits-1:0]          minor_pos;
    logic [CoordBits-1:0]          major_end;
    logic [CoordBits-1:0]          major_span;
    logic [CoordBits-1:0]          minor_span;
    logic [lpw_pkg::ColorBits-1:0] color;
  } cmd_t;

  cmd_t                 cmd;
  logic                 x_gt, x_lt, y_gt, y_lt;
  logic [CoordBits-1:0] dx, dy;
  logic                 steep, swap, minor_gt, minor_lt;

  assign in_ready_o = !q_status_i.full;
  assign push_o     = in_valid_i && !q_status_i.full;

  always_comb begin
    x_gt = start_x_i > end_x_i;
    x_lt = start_x_i < end_x_i;
    y_gt = start_y_i > end_y_i;
    y_lt = start_y_i < end_y_i;
    dx   = x_gt ? (start_x_i - end_x_i) : (end_x_i - start_x_i);
    dy   = y_gt ? (start_y_i - end_y_i) : (end_y_i - start_y_i);
    // Equal spans keep columns as the major axis.
    steep    = dy > dx;
    swap     = steep ? y_gt : x_gt;
    minor_gt = steep ? x_gt : y_gt;
    minor_lt = steep ? x_lt : y_lt;

    cmd.is_start   = (lpw_pkg::mode_e'(mode_i) == lpw_pkg::MODE_START);
    cmd.steep      = steep;
    cmd.major_span = steep ? dy : dx;
    cmd.minor_span = steep ? dx : dy;
    // Walk always runs from the lower major endpoint.
    if (steep) begin
      cmd.major_pos = swap ? end_y_i : start_y_i;
      cmd.major_end = swap ? start_y_i : end_y_i;
      cmd.minor_pos = swap ? end_x_i : start_x_i;
    end else begin
      cmd.major_pos = swap ? end_x_i : start_x_i;
      cmd.major_end = swap ? start_x_i : end_x_i;
      cmd.minor_pos = swap ? end_y_i : start_y_i;
    end
    cmd.dir_down = swap ? minor_gt : minor_lt;
    cmd.color    = {blue_i, green_i, red_i};
  end

  assign cmd_o = cmd;

endmodule

/* src/lpw_back.sv */
// Back end: holds the walker state and emits one result per command.
module lpw_back #(
  parameter int unsigned CoordBits = 10,
  parameter int unsigned CmdW      = 3 + 5 * CoordBits + lpw_pkg::ColorBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic [CmdW-1:0]               cmd_i,
  input  lpw_pkg::queue_status_t        q_status_i,
  output logic                          pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [CoordBits-1:0]          pixel_x_o,
  output logic [CoordBits-1:0]          pixel_y_o,
  output logic [lpw_pkg::ColorBits-1:0] pixel_color_o,
  output logic                          pixel_valid_o,
  output logic                          last_pixel_o
);

  typedef struct packed {
    logic                          is_start;
    logic                          steep;
    logic                          dir_down;
    logic [CoordBits-1:0]          major_pos;
    logic [CoordBits-1:0]          minor_pos;
    logic [CoordBits-1:0]          major_end;
    logic [CoordBits-1:0]          major_span;
    logic [CoordBits-1:0]          minor_span;
    logic [lpw_pkg::ColorBits-1:0] color;
  } cmd_t;

  localparam int unsigned ErrW = CoordBits + 1;

  cmd_t                          cmd;
  logic                          active_q, active_d;
  logic                          steep_q, steep_d;
  logic                          dir_down_q, dir_down_d;
  logic [CoordBits-1:0]          major_pos_q, major_pos_d;
  logic [CoordBits-1:0]          minor_pos_q, minor_pos_d;
  logic [CoordBits-1:0]          major_end_q, major_end_d;
  logic [CoordBits-1:0]          major_span_q, major_span_d;
  logic [CoordBits-1:0]          minor_span_q, minor_span_d;
  logic [lpw_pkg::ColorBits-1:0] color_q, color_d;
  logic [ErrW-1:0]               err_q, err_d;

  logic                          out_valid_q;
  logic [CoordBits-1:0]          px_q, px_d, py_q, py_d;
  logic [lpw_pkg::ColorBits-1:0] pcolor_q, pcolor_d;
  logic                          pvalid_q, pvalid_d, plast_q, plast_d;

  logic                          take, live, last, neg;
  logic [ErrW-1:0]               cur_err, e1, e2;

  assign cmd   = cmd_t'(cmd_i);
  assign take  = !q_status_i.empty && (!out_valid_q || out_ready_i);
  assign pop_o = take;

  always_comb begin
    // Start commands load the walker, then share the step logic.
    steep_d      = cmd.is_start ? cmd.steep      : steep_q;
    dir_down_d   = cmd.is_start ? cmd.dir_down   : dir_down_q;
    major_pos_d  = cmd.is_start ? cmd.major_pos  : major_pos_q;
    minor_pos_d  = cmd.is_start ? cmd.minor_pos  : minor_pos_q;
    major_end_d  = cmd.is_start ? cmd.major_end  : major_end_q;
    major_span_d = cmd.is_start ? cmd.major_span : major_span_q;
    minor_span_d = cmd.is_start ? cmd.minor_span : minor_span_q;
    color_d      = cmd.is_start ? cmd.color      : color_q;
    cur_err      = cmd.is_start ? {2'b00, cmd.major_span[CoordBits-1:1]} : err_q;
    live         = cmd.is_start || active_q;
    last         = (major_pos_d == major_end_d);

    px_d     = live ? (steep_d ? minor_pos_d : major_pos_d) : '0;
    py_d     = live ? (steep_d ? major_pos_d : minor_pos_d) : '0;
    pcolor_d = live ? color_d : '0;
    pvalid_d = live;
    plast_d  = live && last;

    e1  = cur_err - {1'b0, minor_span_d};
    e2  = e1 + {1'b0, major_span_d};
    neg = e1[ErrW-1];

    active_d = live && !last;
    err_d    = cur_err;
    if (live && !last) begin
      err_d       = neg ? e2 : e1;
      major_pos_d = major_pos_d + 1'b1;
      if (neg) begin
        minor_pos_d = dir_down_d ? minor_pos_d + 1'b1 : minor_pos_d - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (take) begin
        active_q <= active_d;
      end
      if (take) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      steep_q      <= steep_d;
      dir_down_q   <= dir_down_d;
      major_pos_q  <= major_pos_d;
      minor_pos_q  <= minor_pos_d;
      major_end_q  <= major_end_d;
      major_span_q <= major_span_d;
      minor_span_q <= minor_span_d;
      color_q      <= color_d;
      err_q        <= err_d;
      px_q         <= px_d;
      py_q         <= py_d;
      pcolor_q     <= pcolor_d;
      pvalid_q     <= pvalid_d;
      plast_q      <= plast_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pixel_x_o     = px_q;
  assign pixel_y_o     = py_q;
  assign pixel_color_o = pcolor_q;
  assign pixel_valid_o = pvalid_q;
  assign last_pixel_o  = plast_q;

endmodule
